// ===== design/pager_char_stream_formatter_unit_assert.svh =====
// Assertion macros for the pager character stream formatter.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef PAGER_CHAR_STREAM_FORMATTER_UNIT_ASSERT_SVH
`define PAGER_CHAR_STREAM_FORMATTER_UNIT_ASSERT_SVH

// Property checked at every clock edge outside of reset.
`define PCSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define PCSF_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pcsf_pkg.sv =====
// Shared types and constants of the pager character stream formatter.
// No dependencies; used by the channel interfaces and the top level.
package pcsf_pkg;

  localparam int unsigned CharW  = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LineW  = 9;
  localparam int unsigned ApbAw  = 4;
  localparam int unsigned ApbDw  = 32;

  // Result kinds.
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_PAGE  = 1'b1;

  // Request actions.
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_EOS  = 1'b1;

  // Characters with special handling.
  localparam logic [CharW-1:0] CHAR_BS    = 7'h08;
  localparam logic [CharW-1:0] CHAR_TAB   = 7'h09;
  localparam logic [CharW-1:0] CHAR_NL    = 7'h0A;
  localparam logic [CharW-1:0] CHAR_VT    = 7'h0B;
  localparam logic [CharW-1:0] CHAR_FF    = 7'h0C;
  localparam logic [CharW-1:0] CHAR_CR    = 7'h0D;
  localparam logic [CharW-1:0] CHAR_ESC   = 7'h1B;
  localparam logic [CharW-1:0] CHAR_SPACE = 7'h20;
  localparam logic [CharW-1:0] CHAR_CARET = 7'h5E;
  localparam logic [CharW-1:0] CHAR_SLASH = 7'h2F;
  localparam logic [CharW-1:0] CHAR_DEL   = 7'h7F;
  localparam logic [CharW-1:0] CARET_OFS  = 7'h40;

  // Configuration register indexes (word address).
  typedef enum logic [1:0] {
    REG_LINE_LEN = 2'd0,
    REG_PAGE_HEIGHT = 2'd1,
    REG_ESC_PASS = 2'd2
  } reg_idx_e;

endpackage

// ===== design/pcsf_if.sv =====
// Valid/ready channel interfaces of the pager character stream formatter.
// Depends on pcsf_pkg for field widths.

// Input channel: one request per text byte or end of stream.
interface pcsf_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [pcsf_pkg::ByteW-1:0]      data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

// Output channel: one terminal character or page break per result.
interface pcsf_out_if;
  logic                            valid;
  logic                            ready;
  logic                            out_kind;
  logic [pcsf_pkg::CharW-1:0]      out_char;
  logic                            last;

  modport source (output valid, out_kind, out_char, last, input ready);
  modport sink (input valid, out_kind, out_char, last, output ready);
endinterface

// ===== design/pager_char_stream_formatter_unit.sv =====
// Pager character stream formatter top level.
// Depends on pcsf_pkg, pcsf_if.sv and pager_char_stream_formatter_unit_assert.svh.
//
// Usage:
//   in_i carries one request per text byte (action 0) or an end of stream
//   (action 1). out_o returns zero to three results per request: an optional
//   page break, then terminal characters; last marks the final result of a
//   request. A request that yields no result produces nothing on out_o.
//   The APB port writes the line length (0x0), page height (0x4) and
//   escape passthrough (0x8); write it only while the block is idle.
// Flow:
//   A request is decoded in the cycle it is accepted and its results sit in
//   a three-entry result buffer from the next cycle on. The buffer drains one
//   result per cycle while out_o.ready is high. A request with no result
//   leaves the buffer empty. A new request is taken in the cycle the last
//   buffered result leaves, so back-to-back single-result requests flow
//   every cycle while out_o.ready is high.
// Reset:
//   Column 0, line count 1, no escape sequence, last shown newline,
//   registers 80 / 24 / 0, result buffer empty.
// Stall:
//   While out_o.ready is low a waiting result holds and in_i.ready stays
//   low until the buffer empties; no result is lost or repeated.
`include "pager_char_stream_formatter_unit_assert.svh"

module pager_char_stream_formatter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pcsf_in_if.sink                       in_i,
  pcsf_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcsf_pkg::ApbAw-1:0]    paddr,
  input  logic [pcsf_pkg::ApbDw-1:0]    pwdata,
  output logic [pcsf_pkg::ApbDw-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned CW = pcsf_pkg::CharW;
  localparam int unsigned BW = pcsf_pkg::ByteW;
  localparam int unsigned LW = pcsf_pkg::LineW;

  // Configuration registers.
  logic [BW-1:0] line_len_q;
  logic [BW-1:0] page_height_q;
  logic          esc_pass_q;

  // Formatter state.
  logic [BW-1:0] col_q, col_d;
  logic [LW-1:0] line_q, line_d;
  logic          esc_q, esc_d;
  logic [CW-1:0] shown_q, shown_d;

  // Result buffer.
  logic          res_kind_q [3];
  logic [CW-1:0] res_char_q [3];
  logic [1:0]    res_cnt_q;
  logic [1:0]    res_rd_q;

  // Decoded results of the request being accepted.
  logic          new_kind [3];
  logic [CW-1:0] new_char [3];
  logic [1:0]    new_cnt;

  logic in_fire, out_fire, cfg_wr;
  pcsf_pkg::reg_idx_e cfg_idx;

  // Saturating column increment.
  function automatic logic [BW-1:0] col_inc(input logic [BW-1:0] col);
    col_inc = (col == {BW{1'b1}}) ? col : col + BW'(1);
  endfunction

  // APB register port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = pcsf_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q    <= BW'(80);
      page_height_q <= BW'(24);
      esc_pass_q    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pcsf_pkg::REG_LINE_LEN: line_len_q <= pwdata[BW-1:0];
        pcsf_pkg::REG_PAGE_HEIGHT: page_height_q <= pwdata[BW-1:0];
        pcsf_pkg::REG_ESC_PASS: esc_pass_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pcsf_pkg::REG_LINE_LEN: prdata = pcsf_pkg::ApbDw'(line_len_q);
      pcsf_pkg::REG_PAGE_HEIGHT: prdata = pcsf_pkg::ApbDw'(page_height_q);
      pcsf_pkg::REG_ESC_PASS: prdata = pcsf_pkg::ApbDw'(esc_pass_q);
      default: prdata = '0;
    endcase
  end

  // Handshakes: a new request is taken once the buffer is empty or drains now.
  assign out_o.valid = (res_rd_q != res_cnt_q);
  assign out_fire    = out_o.valid && out_o.ready;
  assign in_i.ready  = (res_rd_q == res_cnt_q) ||
                       (out_fire && (res_rd_q + 2'd1 == res_cnt_q));
  assign in_fire     = in_i.valid && in_i.ready;

  // Decode one request into up to three results and the next state.
  always_comb begin
    logic [CW-1:0] c;
    logic          is_ctrl;
    logic          is_letter;
    logic          caret;
    logic [CW-1:0] caret_char;
    logic [BW-1:0] col_a;
    logic [CW-1:0] b_char;
    logic          b_record;
    logic [LW-1:0] tab_sum;

    c          = in_i.data_byte[CW-1:0];
    is_ctrl    = (c < pcsf_pkg::CHAR_SPACE) || (c == pcsf_pkg::CHAR_DEL);
    is_letter  = (c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A);
    caret      = 1'b0;
    caret_char = pcsf_pkg::CHAR_SLASH;
    col_a      = col_q;
    b_char     = c;
    b_record   = 1'b1;
    tab_sum    = ({1'b0, col_q} + LW'(8)) & ~LW'(7);

    col_d   = col_q;
    line_d  = line_q;
    esc_d   = esc_q;
    shown_d = shown_q;
    new_cnt = 2'd0;
    for (int i = 0; i < 3; i++) begin
      new_kind[i] = pcsf_pkg::KIND_CHAR;
      new_char[i] = '0;
    end

    if (in_i.action == pcsf_pkg::ACT_EOS) begin
      // End of stream: close the last line and restart the page.
      if (shown_q != pcsf_pkg::CHAR_NL) begin
        new_char[0] = pcsf_pkg::CHAR_NL;
        new_cnt     = 2'd1;
      end
      col_d   = '0;
      line_d  = LW'(1);
      esc_d   = 1'b0;
      shown_d = pcsf_pkg::CHAR_NL;
    end else if (esc_q && !is_ctrl) begin
      // Inside an escape sequence: pass the byte, a letter ends it.
      if (col_q < line_len_q) begin
        new_char[0] = c;
        new_cnt     = 2'd1;
      end
      if (is_letter) begin
        esc_d = 1'b0;
      end
    end else begin
      esc_d = 1'b0;
      // Page break ahead of the byte.
      if (line_q >= {1'b0, page_height_q}) begin
        new_kind[0] = pcsf_pkg::KIND_PAGE;
        new_cnt     = 2'd1;
        line_d      = LW'(1);
      end

      case (c)
        pcsf_pkg::CHAR_VT, pcsf_pkg::CHAR_FF: begin
          line_d = {1'b0, page_height_q} + LW'(1);
          col_d  = '0;
          b_char = pcsf_pkg::CHAR_NL;
        end
        pcsf_pkg::CHAR_NL: begin
          if (line_d != {LW{1'b1}}) begin
            line_d = line_d + LW'(1);
          end
          col_d = '0;
        end
        pcsf_pkg::CHAR_CR: begin
          col_d = '0;
        end
        pcsf_pkg::CHAR_BS: begin
          if (col_q != '0) begin
            col_d = col_q - BW'(1);
          end
        end
        pcsf_pkg::CHAR_TAB: begin
          col_d = tab_sum[BW] ? {BW{1'b1}} : tab_sum[BW-1:0];
        end
        pcsf_pkg::CHAR_DEL: begin
          caret = 1'b1;
        end
        default: begin
          if (c == pcsf_pkg::CHAR_ESC && esc_pass_q) begin
            esc_d    = 1'b1;
            b_record = 1'b0;
          end else if (c < pcsf_pkg::CHAR_SPACE) begin
            caret      = 1'b1;
            caret_char = c | pcsf_pkg::CARET_OFS;
          end else begin
            col_d = col_inc(col_q);
          end
        end
      endcase

      // Caret notation: '^' at the next column, then the mapped character.
      if (caret) begin
        col_a = col_inc(col_q);
        if (col_a < line_len_q) begin
          new_char[new_cnt] = pcsf_pkg::CHAR_CARET;
          new_cnt           = new_cnt + 2'd1;
          shown_d           = pcsf_pkg::CHAR_CARET;
        end
        col_d  = col_inc(col_a);
        b_char = caret_char;
      end

      // Main character, shown only inside the line width.
      if (col_d < line_len_q) begin
        new_char[new_cnt] = b_char;
        new_cnt           = new_cnt + 2'd1;
        if (b_record) begin
          shown_d = b_char;
        end
      end
    end
  end

  // State and result buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      line_q    <= LW'(1);
      esc_q     <= 1'b0;
      shown_q   <= pcsf_pkg::CHAR_NL;
      res_cnt_q <= 2'd0;
      res_rd_q  <= 2'd0;
    end else if (in_fire) begin
      col_q     <= col_d;
      line_q    <= line_d;
      esc_q     <= esc_d;
      shown_q   <= shown_d;
      res_cnt_q <= new_cnt;
      res_rd_q  <= 2'd0;
    end else if (out_fire) begin
      res_rd_q <= res_rd_q + 2'd1;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < 3; i++) begin
        res_kind_q[i] <= new_kind[i];
        res_char_q[i] <= new_char[i];
      end
    end
  end

  assign out_o.out_kind = res_kind_q[res_rd_q];
  assign out_o.out_char = res_char_q[res_rd_q];
  assign out_o.last     = (res_rd_q + 2'd1 == res_cnt_q);

  // A new request never overwrites results still waiting.
  `PCSF_ASSERT(a_no_overwrite, !in_fire || !out_o.valid || (out_fire && out_o.last), "request accepted over pending results")
  // More results of the same request follow a non-final result.
  `PCSF_ASSERT_NEXT(a_burst_continues, out_fire && !out_o.last, out_o.valid, "result burst broken")
  // A page break carries no character.
  `PCSF_ASSERT(a_page_clean, !out_o.valid || out_o.out_kind == pcsf_pkg::KIND_CHAR || out_o.out_char == '0, "page break with character")
  // The line count never drops to zero.
  `PCSF_ASSERT(a_line_nonzero, line_q != '0, "line count is zero")

endmodule
